// File: rtl/matrix_row_operation_engine_assert.svh
`ifndef MATRIX_ROW_OPERATION_ENGINE_ASSERT_SVH
`define MATRIX_ROW_OPERATION_ENGINE_ASSERT_SVH

// same-cycle implication on clk_i, disabled while rst_ni is asserted
`define MROE_ASSERT_NOW(name, lhs, rhs) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (lhs) |-> (rhs)) \
    else $error("mroe assertion failed");

// next-cycle implication on clk_i, disabled while rst_ni is asserted
`define MROE_ASSERT_NEXT(name, lhs, rhs) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (lhs) |=> (rhs)) \
    else $error("mroe assertion failed");

`endif

// File: rtl/mroe_pkg.sv
`default_nettype none

package mroe_pkg;

  // fixed field widths of the stream items
  localparam int KIND_W     = 3;
  localparam int IDX_W      = 4;
  localparam int VAL_W      = 32;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0]  CFG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  CFG_COLS_IN_USE = 1'b1;
  localparam logic [CFG_DATA_W-1:0] CFG_RESET_COUNT = 4'd8;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 3'd0,
    KIND_READ  = 3'd1,
    KIND_SWAP  = 3'd2,
    KIND_SCALE = 3'd3,
    KIND_ADD   = 3'd4
  } mroe_kind_e;

  // controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_CAPTURE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_WRITE_A,
    ST_WRITE_B,
    ST_DONE
  } mroe_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_we;
    logic cap;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic wr_a;
    logic wr_b;
    logic cnt_inc;
    logic out_load;
  } mroe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              reject;
    logic              no_cols;
    logic              col_last;
    logic              clr_last;
    logic              out_free;
  } mroe_status_t;

endpackage

`default_nettype wire

// File: rtl/mroe_ram.sv
`default_nettype none

module mroe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr0_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr1_i,
  output logic      [WIDTH-1:0]                       rdata0_o,
  output logic      [WIDTH-1:0]                       rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

`default_nettype wire

// File: rtl/mroe_ctrl.sv
`default_nettype none

`include "matrix_row_operation_engine_assert.svh"

module mroe_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire mroe_pkg::mroe_status_t status_i,
  output mroe_pkg::mroe_cmd_t         cmd_o
);

  import mroe_pkg::*;

  mroe_state_e state_q;
  mroe_state_e state_d;

  // state register, starts with the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.reject) begin
          state_d = ST_DONE;
        end else begin
          case (status_i.kind)
            KIND_WRITE: state_d = ST_WRITE_A;
            KIND_READ:  state_d = ST_READ;
            KIND_SWAP, KIND_SCALE, KIND_ADD: begin
              state_d = status_i.no_cols ? ST_DONE : ST_READ;
            end
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        cmd_o.cap = 1'b1;
        case (status_i.kind)
          KIND_READ: state_d = ST_DONE;
          KIND_SWAP: state_d = ST_WRITE_A;
          default:   state_d = ST_MUL_LO;
        endcase
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_WRITE_A;
      end
      ST_WRITE_A: begin
        cmd_o.wr_a = 1'b1;
        case (status_i.kind)
          KIND_WRITE: state_d = ST_DONE;
          KIND_SWAP:  state_d = ST_WRITE_B;
          default: begin
            if (status_i.col_last) begin
              state_d = ST_DONE;
            end else begin
              cmd_o.cnt_inc = 1'b1;
              state_d       = ST_READ;
            end
          end
        endcase
      end
      ST_WRITE_B: begin
        cmd_o.wr_b = 1'b1;
        if (status_i.col_last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // checks
  `MROE_ASSERT_NEXT(a_accept_decodes, in_valid_i && in_ready_o, state_q == ST_DECODE)
  `MROE_ASSERT_NEXT(a_reject_to_done, state_q == ST_DECODE && status_i.reject, state_q == ST_DONE)
  `MROE_ASSERT_NOW(a_no_write_on_reject, cmd_o.wr_a || cmd_o.wr_b, !status_i.reject)
  `MROE_ASSERT_NOW(a_no_step_past_last, cmd_o.cnt_inc, !status_i.col_last)

endmodule

`default_nettype wire

// File: rtl/mroe_dp.sv
`default_nettype none

module mroe_dp #(
  parameter int MAX_ROWS    = 8,
  parameter int MAX_COLS    = 8,
  parameter int ENTRY_WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [mroe_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [mroe_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic [mroe_pkg::IN_DATA_W-1:0]      in_data_i,
  input  wire logic [mroe_pkg::KIND_W-1:0]         in_kind_i,
  input  wire mroe_pkg::mroe_cmd_t                 cmd_i,
  output mroe_pkg::mroe_status_t                   status_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [mroe_pkg::OUT_DATA_W-1:0]          out_data_o,
  output logic                                     out_status_o
);

  import mroe_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int EW     = ENTRY_WIDTH;
  localparam logic signed [63:0] EMAX = {{(65 - EW){1'b0}}, {(EW - 1){1'b1}}};
  localparam logic signed [63:0] EMIN = ~EMAX;
  localparam logic signed [63:0] R32_MAX = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] R32_MIN = -64'sh0000_0000_8000_0000;

  // configuration registers
  logic [CFG_DATA_W-1:0] rows_q;
  logic [CFG_DATA_W-1:0] cols_q;

  // current item
  logic [KIND_W-1:0]       kind_q;
  logic [IDX_W-1:0]        row_a_q;
  logic [IDX_W-1:0]        row_b_q;
  logic [IDX_W-1:0]        column_q;
  logic signed [VAL_W-1:0] value_q;
  logic signed [VAL_W-1:0] scalar_q;

  // sequencing counters
  logic [CNT_W-1:0]  cnt_q;
  logic [ADDR_W-1:0] clr_cnt_q;

  // operands and arithmetic
  logic signed [EW-1:0] opa_q;
  logic signed [EW-1:0] opb_q;
  logic signed [64:0]   lo_q;
  logic signed [64:0]   hi_q;
  logic signed [95:0]   full_q;

  // result register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_status_q;

  logic        row_a_ok;
  logic        row_b_ok;
  logic        col_ok;
  logic        reject;
  logic        entry_op;
  int          n_cols;
  int          a_col;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [EW-1:0]     ram_rdata0;
  logic [EW-1:0]     ram_rdata1;

  logic signed [EW-1:0] mul_x;
  logic signed [63:0]   mul_x64;
  logic signed [32:0]   mul_a;
  logic signed [64:0]   mul_p;
  logic signed [79:0]   prod_floor;
  logic signed [EW-1:0] prod_w;
  logic signed [EW:0]   sum_raw;
  logic signed [EW-1:0] sum_w;
  logic signed [EW-1:0] arith_w;
  logic signed [63:0]   wr_val64;
  logic signed [EW-1:0] write_w;
  logic signed [63:0]   rd_val64;
  logic [OUT_DATA_W-1:0] rd32;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_RESET_COUNT;
      cols_q <= CFG_RESET_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS_IN_USE: rows_q <= cfg_data_i;
        CFG_COLS_IN_USE: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item capture, field layout from the low bit up
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= in_kind_i;
      row_a_q  <= in_data_i[3:0];
      row_b_q  <= in_data_i[7:4];
      column_q <= in_data_i[11:8];
      value_q  <= in_data_i[43:12];
      scalar_q <= in_data_i[75:44];
    end
  end

  // index checks
  always_comb begin
    row_a_ok = (row_a_q != '0) && (row_a_q <= rows_q) && (int'(row_a_q) <= MAX_ROWS);
    row_b_ok = (row_b_q != '0) && (row_b_q <= rows_q) && (int'(row_b_q) <= MAX_ROWS);
    col_ok   = (column_q != '0) && (column_q <= cols_q) && (int'(column_q) <= MAX_COLS);
    case (kind_q)
      KIND_WRITE, KIND_READ: reject = !(row_a_ok && col_ok);
      KIND_SWAP, KIND_ADD:   reject = !(row_a_ok && row_b_ok && (row_a_q != row_b_q));
      KIND_SCALE:            reject = !row_a_ok;
      default:               reject = 1'b1;
    endcase
  end

  // column walk and clearing counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.clr_we) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // row-major addresses with a stride of MAX_COLS
  always_comb begin
    n_cols   = (int'(cols_q) < MAX_COLS) ? int'(cols_q) : MAX_COLS;
    entry_op = (kind_q == KIND_WRITE) || (kind_q == KIND_READ);
    a_col    = entry_op ? (int'(column_q) - 1) : int'(cnt_q);
    addr_a   = ADDR_W'((int'(row_a_q) - 1) * MAX_COLS + a_col);
    addr_b   = ADDR_W'((int'(row_b_q) - 1) * MAX_COLS + int'(cnt_q));
  end

  // entry store
  mroe_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr0_i (addr_a),
    .raddr1_i (addr_b),
    .rdata0_o (ram_rdata0),
    .rdata1_o (ram_rdata1)
  );

  // operand capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      opa_q <= ram_rdata0;
      opb_q <= ram_rdata1;
    end
  end

  // shared 33x32 multiplier, low then high half of the entry
  always_comb begin
    mul_x   = (kind_q == KIND_SCALE) ? opa_q : opb_q;
    mul_x64 = 64'(mul_x);
    mul_a   = cmd_i.mul_hi ? $signed({mul_x64[63], mul_x64[63:32]})
                           : $signed({1'b0, mul_x64[31:0]});
    mul_p   = mul_a * scalar_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      lo_q <= mul_p;
    end
    if (cmd_i.mul_hi) begin
      hi_q <= mul_p;
    end
    if (cmd_i.sum) begin
      full_q <= 96'(lo_q) + (96'(hi_q) <<< 32);
    end
  end

  // floor shift, saturation and the row-add sum
  always_comb begin
    prod_floor = $signed(full_q[95:16]);
    if (prod_floor > 80'(EMAX)) begin
      prod_w = EW'(EMAX);
    end else if (prod_floor < 80'(EMIN)) begin
      prod_w = EW'(EMIN);
    end else begin
      prod_w = prod_floor[EW-1:0];
    end
    sum_raw = (EW + 1)'(opa_q) + (EW + 1)'(prod_w);
    if (sum_raw > (EW + 1)'(EMAX)) begin
      sum_w = EW'(EMAX);
    end else if (sum_raw < (EW + 1)'(EMIN)) begin
      sum_w = EW'(EMIN);
    end else begin
      sum_w = sum_raw[EW-1:0];
    end
    arith_w = (kind_q == KIND_ADD) ? sum_w : prod_w;
  end

  // written value limited to the entry range, read value to 32 bits
  always_comb begin
    wr_val64 = 64'(value_q);
    if (wr_val64 > EMAX) begin
      write_w = EW'(EMAX);
    end else if (wr_val64 < EMIN) begin
      write_w = EW'(EMIN);
    end else begin
      write_w = EW'(wr_val64);
    end
    rd_val64 = 64'(opa_q);
    if (rd_val64 > R32_MAX) begin
      rd32 = R32_MAX[31:0];
    end else if (rd_val64 < R32_MIN) begin
      rd32 = R32_MIN[31:0];
    end else begin
      rd32 = rd_val64[31:0];
    end
  end

  // store write port
  always_comb begin
    ram_we    = cmd_i.clr_we || cmd_i.wr_a || cmd_i.wr_b;
    ram_waddr = addr_a;
    ram_wdata = arith_w;
    if (cmd_i.clr_we) begin
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (cmd_i.wr_b) begin
      ram_waddr = addr_b;
      ram_wdata = opa_q;
    end else begin
      case (kind_q)
        KIND_WRITE: ram_wdata = write_w;
        KIND_SWAP:  ram_wdata = opb_q;
        default:    ram_wdata = arith_w;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q   <= ((kind_q == KIND_READ) && !reject) ? rd32 : '0;
      out_status_q <= reject;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;

  // status toward the controller
  always_comb begin
    status_o.kind     = kind_q;
    status_o.reject   = reject;
    status_o.no_cols  = (cols_q == '0);
    status_o.col_last = ((int'(cnt_q) + 1) == n_cols);
    status_o.clr_last = (clr_cnt_q == ADDR_W'(DEPTH - 1));
    status_o.out_free = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

// File: rtl/matrix_row_operation_engine.sv
// channel   direction  width  contents
// cfg       in         1+4    cfg_we_i, cfg_idx_i (0 rows, 1 cols), cfg_data_i
// s_axis    in         80+3   one operation request
// m_axis    out        32+1   read value and status, one per request
//
// scale and row add run one 33x32 multiplier twice per column, then a
//   sum and a store write; swap needs two store writes per column
// after reset every store entry is cleared to zero; no requests are taken meanwhile
// a result waits in the output register; the next request is taken meanwhile
//   and its result is held back until the register frees up
`default_nettype none

module matrix_row_operation_engine #(
  parameter int MAX_ROWS    = 8,
  parameter int MAX_COLS    = 8,
  parameter int ENTRY_WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [mroe_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [mroe_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // row_a[3:0], row_b[7:4], column[11:8], value[43:12], scalar[75:44], zero pad
  input  wire logic [mroe_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // kind[2:0]
  input  wire logic [mroe_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // read_value[31:0]
  output logic [mroe_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  // status[0]
  output logic                                     m_axis_tuser
);

  import mroe_pkg::*;

  mroe_cmd_t    cmd;
  mroe_status_t status;

  // sequencer
  mroe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // store, arithmetic and result register
  mroe_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (s_axis_tdata),
    .in_kind_i    (s_axis_tuser),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import mroe_pkg::*;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLS    = 8;
  localparam int STALL_LIMIT = 5000;

  // codes with no member in the package
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // q16.16 constants
  localparam logic signed [VAL_W-1:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [VAL_W-1:0] Q_HALF = 32'sh0000_8000;
  localparam logic signed [VAL_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] Q_MIN  = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] Q_NEG1 = 32'shFFFF_FFFF;

  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic [IDX_W-1:0]        row_a;
    logic [IDX_W-1:0]        row_b;
    logic [IDX_W-1:0]        column;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] scalar;
    bit                      drain_first;
  } matrix_op_t;

  typedef struct {
    logic [OUT_DATA_W-1:0] read_value;
    logic                  status;
  } op_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata;
  logic [KIND_W-1:0]       s_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;
  logic                    m_axis_tuser;

  // predictor state
  logic signed [VAL_W-1:0] shadow_matrix [MAX_ROWS][MAX_COLS];
  logic [CFG_DATA_W-1:0]   cfg_rows;
  logic [CFG_DATA_W-1:0]   cfg_cols;

  matrix_op_t pending_ops[$];
  op_result_t awaited_results[$];
  matrix_op_t op_on_bus;
  int unsigned ops_issued;
  int unsigned ops_taken;
  int unsigned fail_count;
  int unsigned stall_cycles;
  int unsigned in_gap;
  int unsigned out_stall;
  bit          idle_on;

  matrix_row_operation_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // clamp to the 32-bit entry range
  function automatic logic signed [VAL_W-1:0] sat_entry(input longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[VAL_W-1:0];
  endfunction

  // floor(a * s / 2^16), saturated
  function automatic logic signed [VAL_W-1:0] q_mul(input logic signed [VAL_W-1:0] a,
                                                    input logic signed [VAL_W-1:0] s);
    longint p;
    p = (longint'(a) * longint'(s)) >>> 16;
    return sat_entry(p);
  endfunction

  function automatic bit row_ok(input logic [IDX_W-1:0] r);
    return r >= 1 && r <= cfg_rows && r <= MAX_ROWS;
  endfunction

  function automatic bit col_ok(input logic [IDX_W-1:0] c);
    return c >= 1 && c <= cfg_cols && c <= MAX_COLS;
  endfunction

  // apply one request to the shadow matrix and give its result
  function automatic op_result_t apply_row_op(input matrix_op_t op);
    op_result_t res;
    int ncols;
    int ra;
    int rb;
    logic signed [VAL_W-1:0] t;
    res.read_value = '0;
    res.status     = STATUS_REJECT;
    ncols = (cfg_cols < MAX_COLS) ? int'(cfg_cols) : MAX_COLS;
    ra = int'(op.row_a) - 1;
    rb = int'(op.row_b) - 1;
    case (op.kind)
      KIND_WRITE, KIND_READ: begin
        if (row_ok(op.row_a) && col_ok(op.column)) begin
          if (op.kind == KIND_WRITE) begin
            shadow_matrix[ra][op.column - 1] = op.value;
          end else begin
            res.read_value = shadow_matrix[ra][op.column - 1];
          end
          res.status = STATUS_DONE;
        end
      end
      KIND_SWAP, KIND_ADD: begin
        if (row_ok(op.row_a) && row_ok(op.row_b) && op.row_a != op.row_b) begin
          for (int c = 0; c < ncols; c++) begin
            if (op.kind == KIND_SWAP) begin
              t = shadow_matrix[ra][c];
              shadow_matrix[ra][c] = shadow_matrix[rb][c];
              shadow_matrix[rb][c] = t;
            end else begin
              shadow_matrix[ra][c] = sat_entry(longint'(shadow_matrix[ra][c]) +
                                     longint'(q_mul(shadow_matrix[rb][c], op.scalar)));
            end
          end
          res.status = STATUS_DONE;
        end
      end
      KIND_SCALE: begin
        if (row_ok(op.row_a)) begin
          for (int c = 0; c < ncols; c++)
            shadow_matrix[ra][c] = q_mul(shadow_matrix[ra][c], op.scalar);
          res.status = STATUS_DONE;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic push_op(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] ra,
                         input logic [IDX_W-1:0] rb, input logic [IDX_W-1:0] col,
                         input logic signed [VAL_W-1:0] value,
                         input logic signed [VAL_W-1:0] scalar, input bit drain = 1'b0);
    matrix_op_t op;
    op.kind        = kind;
    op.row_a       = ra;
    op.row_b       = rb;
    op.column      = col;
    op.value       = value;
    op.scalar      = scalar;
    op.drain_first = drain;
    pending_ops.push_back(op);
  endtask

  // index that is mostly valid under the current setting
  function automatic logic [IDX_W-1:0] rand_index(input logic [CFG_DATA_W-1:0] lim_cfg,
                                                  input int max_lim);
    int lim;
    lim = (lim_cfg == 0) ? 1 : ((lim_cfg > max_lim) ? max_lim : int'(lim_cfg));
    if ($urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, 15));
    return IDX_W'($urandom_range(1, lim));
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom;
      2:       return ($urandom_range(0, 1) == 1) ? Q_MAX : Q_MIN;
      3, 4:    return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
      default: return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_scalar();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0:       return Q_MAX;
          1:       return Q_MIN;
          2:       return Q_ONE;
          3:       return -Q_ONE;
          default: return '0;
        endcase
      end
      default: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic matrix_op_t rand_op();
    matrix_op_t op;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      op.kind = KIND_WRITE;
    else if (pick < 50) op.kind = KIND_READ;
    else if (pick < 60) op.kind = KIND_SWAP;
    else if (pick < 72) op.kind = KIND_SCALE;
    else if (pick < 92) op.kind = KIND_ADD;
    else                op.kind = KIND_W'($urandom_range(0, 7));
    op.row_a       = rand_index(cfg_rows, MAX_ROWS);
    op.row_b       = rand_index(cfg_rows, MAX_ROWS);
    op.column      = rand_index(cfg_cols, MAX_COLS);
    op.value       = rand_value();
    op.scalar      = rand_scalar();
    op.drain_first = 1'b0;
    return op;
  endfunction

  // block until every request is taken and answered
  task automatic wait_quiet();
    while (pending_ops.size() != 0 || ops_taken != ops_issued || awaited_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_ROWS_IN_USE) cfg_rows = data;
    else cfg_cols = data;
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] rows, input logic [CFG_DATA_W-1:0] cols,
                           input int n, input bit idle);
    matrix_op_t op;
    wait_quiet();
    write_cfg(CFG_ROWS_IN_USE, rows);
    write_cfg(CFG_COLS_IN_USE, cols);
    idle_on = idle;
    for (int i = 0; i < n; i++) begin
      op = rand_op();
      // one request per phase waits for the pipe to drain
      if (i == n / 2) op.drain_first = 1'b1;
      pending_ops.push_back(op);
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || ops_taken == ops_issued)) begin
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 11);
        s_axis_tvalid <= 1'b0;
      end else if (pending_ops.size() != 0 &&
                   (!pending_ops[0].drain_first || awaited_results.size() == 0)) begin
        op_on_bus = pending_ops.pop_front();
        s_axis_tdata <= {4'b0, op_on_bus.scalar, op_on_bus.value, op_on_bus.column,
                         op_on_bus.row_b, op_on_bus.row_a};
        s_axis_tuser  <= op_on_bus.kind;
        s_axis_tvalid <= 1'b1;
        ops_issued++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(negedge clk_i) begin
    if (!idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 6) == 0) begin
      out_stall = $urandom_range(0, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor: check results, predict accepted requests, watchdog
  always @(posedge clk_i) begin
    op_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: read_value %h status %b", m_axis_tdata, m_axis_tuser);
        end else begin
          want = awaited_results.pop_front();
          if (m_axis_tdata !== want.read_value || m_axis_tuser !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: read_value %h status %b, wanted %h status %b",
                       m_axis_tdata, m_axis_tuser, want.read_value, want.status);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(apply_row_op(op_on_bus));
        ops_taken++;
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("matrix_row_operation_engine verification failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_rows      = CFG_RESET_COUNT;
    cfg_cols      = CFG_RESET_COUNT;
    ops_issued    = 0;
    ops_taken     = 0;
    fail_count    = 0;
    stall_cycles  = 0;
    in_gap        = 0;
    out_stall     = 0;
    idle_on       = 1'b1;
    for (int r = 0; r < MAX_ROWS; r++)
      for (int c = 0; c < MAX_COLS; c++)
        shadow_matrix[r][c] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, saturation, rounding, bad indexes, unknown kinds
    push_op(KIND_WRITE, 1, 0, 1, Q_MAX, 0);
    push_op(KIND_WRITE, 8, 0, 8, Q_MIN, 0);
    push_op(KIND_READ, 1, 0, 1, 0, 0);
    push_op(KIND_READ, 8, 0, 8, 0, 0);
    push_op(KIND_WRITE, 1, 0, 2, Q_ONE, 0);
    push_op(KIND_WRITE, 2, 0, 8, 32'sh0003_0000, 0);
    push_op(KIND_SCALE, 1, 0, 0, 0, Q_MAX);
    push_op(KIND_READ, 1, 0, 1, 0, 0);
    push_op(KIND_READ, 1, 0, 2, 0, 0);
    push_op(KIND_ADD, 2, 8, 0, 0, Q_MIN);
    push_op(KIND_READ, 2, 0, 8, 0, 0);
    push_op(KIND_SWAP, 1, 8, 0, 0, 0);
    push_op(KIND_READ, 8, 0, 1, 0, 0);
    push_op(KIND_READ, 0, 1, 1, 0, 0);
    push_op(KIND_WRITE, 9, 0, 1, Q_ONE, 0);
    push_op(KIND_READ, 1, 0, 0, 0, 0);
    push_op(KIND_READ, 15, 15, 15, Q_NEG1, Q_NEG1);
    push_op(KIND_SWAP, 3, 3, 1, 0, 0);
    push_op(KIND_ADD, 4, 4, 1, 0, Q_ONE);
    push_op(KIND_SCALE, 0, 1, 1, 0, Q_ONE);
    push_op(KIND_SCALE, 5, 0, 15, 0, Q_ONE);
    push_op(KIND_UNUSED_LO, 1, 2, 1, Q_ONE, Q_ONE);
    push_op(KIND_UNUSED_HI, 15, 15, 15, Q_NEG1, Q_NEG1);
    push_op(KIND_WRITE, 3, 0, 1, Q_NEG1, 0);
    push_op(KIND_SCALE, 3, 0, 0, 0, Q_HALF, 1'b1);
    push_op(KIND_READ, 3, 0, 1, 0, 0);

    // random phases over several register settings
    run_phase(1, 1, 60, 1'b1);
    run_phase(3, 5, 90, 1'b1);
    run_phase(0, 8, 40, 1'b1);
    run_phase(8, 0, 40, 1'b1);
    run_phase(15, 15, 100, 1'b1);
    run_phase(5, 9, 90, 1'b0);
    run_phase(8, 1, 80, 1'b1);
    run_phase(2, 8, 80, 1'b1);
    run_phase(8, 8, 120, 1'b1);
    run_phase(8, 8, 100, 1'b0);

    wait_quiet();
    repeat (60) @(negedge clk_i);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("matrix_row_operation_engine verification clean");
    end else begin
      $display("matrix_row_operation_engine verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/mroe_pkg.sv
rtl/mroe_ram.sv
rtl/mroe_ctrl.sv
rtl/mroe_dp.sv
rtl/matrix_row_operation_engine.sv
tb/sv/tb.sv
